FILE: src/adcagc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcagc_pkg: shared types and constants for the adc config word block
// Request and result structs, register indexes, opcodes and reset values.
// ----------------------------------------------------------------------------
package adcagc_pkg;

  typedef enum logic [1:0] {
    OP_SINGLE   = 2'd0,
    OP_CONT     = 2'd1,
    OP_SET_GAIN = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_DIFF_MODE  = 3'd0,
    CFG_DATA_RATE  = 3'd1,
    CFG_AGC_MASK   = 3'd2,
    CFG_HIGH_LIMIT = 3'd3,
    CFG_LOW_LIMIT  = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] HIGH_LIMIT_RST = 16'd26213;
  localparam logic [15:0] LOW_LIMIT_RST  = 16'd6553;
  localparam logic [2:0]  GAIN_RST       = 3'd2;
  localparam logic [2:0]  GAIN_MAX       = 3'd5;
  localparam logic [2:0]  GAIN_MIN       = 3'd0;

  localparam logic [15:0] WORD_START     = 16'h8000;
  localparam logic [15:0] WORD_SINGLE_EN = 16'h4000;
  localparam logic [15:0] WORD_MODE      = 16'h0100;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         channel;
    logic signed [15:0] adc_result;
    logic [2:0]         gain_value;
  } in_req_t;

  typedef struct packed {
    logic               config_valid;
    logic [15:0]        config_word;
    logic [1:0]         sample_channel;
    logic signed [15:0] sample_value;
    logic [2:0]         gain_used;
    logic [2:0]         gain_next;
  } out_rsp_t;

  typedef struct packed {
    logic        diff_mode;
    logic [2:0]  data_rate;
    logic [3:0]  agc_mask;
    logic [15:0] high_limit;
    logic [15:0] low_limit;
  } cfg_t;

  typedef struct packed {
    logic       gain_we;
    logic [1:0] gain_ch;
    logic [2:0] gain_val;
    logic       cur_we;
    logic [1:0] cur_ch;
  } upd_t;

endpackage

FILE: src/adcagc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcagc_cfg_regs: configuration register file
// Holds mode, rate, auto gain enables and the two magnitude limits.
// ----------------------------------------------------------------------------
module adcagc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output adcagc_pkg::cfg_t    cfg_o
);
  import adcagc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DIFF_MODE:  cfg_d.diff_mode  = cfg_data_i[0];
        CFG_DATA_RATE:  cfg_d.data_rate  = cfg_data_i[2:0];
        CFG_AGC_MASK:   cfg_d.agc_mask   = cfg_data_i[3:0];
        CFG_HIGH_LIMIT: cfg_d.high_limit = cfg_data_i;
        CFG_LOW_LIMIT:  cfg_d.low_limit  = cfg_data_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diff_mode  <= 1'b0;
      cfg_q.data_rate  <= 3'd0;
      cfg_q.agc_mask   <= 4'd0;
      cfg_q.high_limit <= HIGH_LIMIT_RST;
      cfg_q.low_limit  <= LOW_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/adcagc_item_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcagc_item_eval: per-request evaluation
// Builds the config word, steps the channel gain and forms the state update.
// ----------------------------------------------------------------------------
module adcagc_item_eval #(
  parameter int NUM_CHANNELS = 4
) (
  input  adcagc_pkg::in_req_t  req_i,
  input  adcagc_pkg::cfg_t     cfg_i,
  input  logic [2:0]           gain_i [NUM_CHANNELS],
  input  logic [1:0]           cur_ch_i,
  output adcagc_pkg::out_rsp_t rsp_o,
  output adcagc_pkg::upd_t     upd_o
);
  import adcagc_pkg::*;

  logic [1:0]  sel_ch;
  logic        present;
  logic [2:0]  g_sel;
  logic [2:0]  g_step;
  logic [16:0] mag;
  logic        agc_en;
  logic [15:0] word;

  // channel whose gain this request touches
  always_comb begin
    if (req_i.operation == OP_CONT) begin
      sel_ch = cur_ch_i;
    end else begin
      sel_ch = req_i.channel;
    end
  end

  assign present = {1'b0, sel_ch} < 3'(NUM_CHANNELS);

  always_comb begin
    g_sel = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (sel_ch == 2'(c)) begin
        g_sel = gain_i[c];
      end
    end
  end

  // magnitude, most negative maps to 32768
  assign mag = req_i.adc_result[15] ? (17'h10000 - {1'b0, req_i.adc_result})
                                    : {1'b0, req_i.adc_result};
  assign agc_en = cfg_i.agc_mask[sel_ch];

  always_comb begin
    g_step = g_sel;
    if (agc_en) begin
      priority if (mag > {1'b0, cfg_i.high_limit} && g_sel > GAIN_MIN) begin
        g_step = g_sel - 3'd1;
      end else if (mag < {1'b0, cfg_i.low_limit} && g_sel < GAIN_MAX) begin
        g_step = g_sel + 3'd1;
      end else begin
        g_step = g_sel;
      end
    end
  end

  assign word = WORD_START | (cfg_i.diff_mode ? 16'h0000 : WORD_SINGLE_EN)
              | {2'b00, req_i.channel, 12'h000}
              | {4'h0, (present ? g_sel : 3'd0), 9'h000}
              | WORD_MODE | {8'h00, cfg_i.data_rate, 5'h00};

  always_comb begin
    rsp_o = '0;
    upd_o = '0;
    rsp_o.sample_channel = cur_ch_i;
    upd_o.gain_ch = sel_ch;
    upd_o.cur_ch  = req_i.channel;
    unique case (req_i.operation)
      OP_SINGLE: begin
        rsp_o.config_valid   = 1'b1;
        rsp_o.config_word    = word;
        rsp_o.sample_channel = req_i.channel;
        rsp_o.sample_value   = req_i.adc_result;
        rsp_o.gain_used      = present ? g_sel : 3'd0;
        rsp_o.gain_next      = present ? g_step : 3'd0;
        upd_o.gain_we        = present;
        upd_o.gain_val       = g_step;
        upd_o.cur_we         = 1'b1;
      end
      OP_CONT: begin
        rsp_o.sample_value   = req_i.adc_result;
        rsp_o.gain_used      = present ? g_sel : 3'd0;
        rsp_o.gain_next      = present ? g_step : 3'd0;
        upd_o.gain_we        = present;
        upd_o.gain_val       = g_step;
      end
      OP_SET_GAIN: begin
        rsp_o.sample_channel = req_i.channel;
        rsp_o.gain_used      = present ? g_sel : 3'd0;
        rsp_o.gain_next      = present ? req_i.gain_value : 3'd0;
        upd_o.gain_we        = present;
        upd_o.gain_val       = req_i.gain_value;
      end
      default: begin
        rsp_o.config_valid   = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/adc_config_word_with_auto_gain.sv
`timescale 1ns / 1ps
// A request is captured in the input register, its result in the result register.
// Throughput: one request per cycle unless results stall; gain state is read and
// written in the evaluation stage, so each request sees the prior one's update.
// Reset: asynchronous, active low; gains return to code 2, current channel to
// 0, config registers to their defaults, both stages empty.
// ----------------------------------------------------------------------------
// adc_config_word_with_auto_gain: adc config word builder with auto gain
// Input register, evaluation stage with per-channel gain state, result register.
// ----------------------------------------------------------------------------
module adc_config_word_with_auto_gain #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  adcagc_pkg::in_req_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output adcagc_pkg::out_rsp_t out_rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import adcagc_pkg::*;

  cfg_t     cfg;
  in_req_t  s1_q;
  logic     s1_valid_q;
  out_rsp_t out_q;
  logic     out_valid_q;
  logic     advance;
  logic     commit;
  logic [2:0] gain_q [NUM_CHANNELS];
  logic [1:0] cur_ch_q;
  out_rsp_t rsp;
  upd_t     upd;

  adcagc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  adcagc_item_eval #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_eval (
    .req_i    (s1_q),
    .cfg_i    (cfg),
    .gain_i   (gain_q),
    .cur_ch_i (cur_ch_q),
    .rsp_o    (rsp),
    .upd_o    (upd)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign commit     = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_req_i;
    end
    if (commit) begin
      out_q <= rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_ch_q <= 2'd0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        gain_q[c] <= GAIN_RST;
      end
    end else if (commit) begin
      if (upd.cur_we) begin
        cur_ch_q <= upd.cur_ch;
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (upd.gain_we && upd.gain_ch == 2'(c)) begin
          gain_q[c] <= upd.gain_val;
        end
      end
    end
  end

endmodule

FILE: src/adcagc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcagc_checker: port-level checks for the adc config word block
// Result handshake and config word consistency, bound to the top level.
// ----------------------------------------------------------------------------
module adcagc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input adcagc_pkg::out_rsp_t out_rsp_o
);
  import adcagc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped or changed while stalled");

  // empty output stage never blocks requests
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request blocked with empty output stage");

  // issued word carries start and single-shot bits and its channel
  a_word_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.config_valid |->
      out_rsp_o.config_word[15] && out_rsp_o.config_word[8] &&
      out_rsp_o.config_word[13:12] == out_rsp_o.sample_channel)
    else $error("malformed config word");

  // no word without config_valid
  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.config_valid |-> out_rsp_o.config_word == 16'h0000)
    else $error("config word set without config_valid");

endmodule

bind adc_config_word_with_auto_gain adcagc_checker u_adcagc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

FILE: tb/sv/adc_config_word_with_auto_gain_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_config_word_with_auto_gain_test: self-checking bench for the adc block
// Drives requests and register writes with random idle gaps and result stalls,
// predicts every result with a per-channel gain model, and checks each field.
// ----------------------------------------------------------------------------
module adc_config_word_with_auto_gain_test;
  import adcagc_pkg::*;

  localparam int CHANNELS = 4;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 105;
  localparam int SETTLE_CYCLES = 4;

  class gain_scoreboard;
    cfg_t settings;
    logic [2:0] gain_code [CHANNELS];
    logic [1:0] last_channel;
    out_rsp_t expected_rsps [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      settings = '{diff_mode: 1'b0, data_rate: 3'd0, agc_mask: 4'd0,
                   high_limit: HIGH_LIMIT_RST, low_limit: LOW_LIMIT_RST};
      foreach (gain_code[i]) gain_code[i] = GAIN_RST;
      last_channel = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CFG_DIFF_MODE:  settings.diff_mode = data[0];
        CFG_DATA_RATE:  settings.data_rate = data[2:0];
        CFG_AGC_MASK:   settings.agc_mask = data[3:0];
        CFG_HIGH_LIMIT: settings.high_limit = data;
        CFG_LOW_LIMIT:  settings.low_limit = data;
        default: ;
      endcase
    endfunction

    // gain code after one auto gain decision on a present channel
    function logic [2:0] stepped_gain(logic [1:0] ch, logic signed [15:0] sample);
      logic [16:0] mag;
      logic [2:0] g;
      g = gain_code[ch];
      mag = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
      if (!settings.agc_mask[ch]) return g;
      if (mag > {1'b0, settings.high_limit} && g > GAIN_MIN) return g - 3'd1;
      if (mag < {1'b0, settings.low_limit} && g < GAIN_MAX) return g + 3'd1;
      return g;
    endfunction

    function void note_request(in_req_t req);
      out_rsp_t rsp;
      logic [2:0] g;
      rsp = '0;
      rsp.sample_channel = last_channel;
      case (req.operation)
        OP_SINGLE: begin
          g = (req.channel < CHANNELS) ? gain_code[req.channel] : 3'd0;
          rsp.config_valid = 1'b1;
          rsp.config_word = WORD_START | WORD_MODE
                          | (settings.diff_mode ? 16'h0000 : WORD_SINGLE_EN)
                          | (16'(req.channel) << 12) | (16'(g) << 9)
                          | (16'(settings.data_rate) << 5);
          last_channel = req.channel;
          rsp.sample_channel = req.channel;
          rsp.sample_value = req.adc_result;
          if (req.channel < CHANNELS) begin
            rsp.gain_used = g;
            gain_code[req.channel] = stepped_gain(req.channel, req.adc_result);
            rsp.gain_next = gain_code[req.channel];
          end
        end
        OP_CONT: begin
          rsp.sample_value = req.adc_result;
          if (last_channel < CHANNELS) begin
            rsp.gain_used = gain_code[last_channel];
            gain_code[last_channel] = stepped_gain(last_channel, req.adc_result);
            rsp.gain_next = gain_code[last_channel];
          end
        end
        OP_SET_GAIN: begin
          rsp.sample_channel = req.channel;
          if (req.channel < CHANNELS) begin
            rsp.gain_used = gain_code[req.channel];
            gain_code[req.channel] = req.gain_value;
            rsp.gain_next = req.gain_value;
          end
        end
        default: ;
      endcase
      expected_rsps.push_back(rsp);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %0h, expected %0h", checked, what, got, want);
      mismatches++;
    endtask

    task check_result(out_rsp_t got);
      out_rsp_t want;
      if (expected_rsps.size() == 0) begin
        report("result with nothing pending, config_word", 32'(got.config_word), '0);
        return;
      end
      want = expected_rsps.pop_front();
      if (got.config_valid !== want.config_valid)
        report("config_valid", 32'(got.config_valid), 32'(want.config_valid));
      if (got.config_word !== want.config_word)
        report("config_word", 32'(got.config_word), 32'(want.config_word));
      if (got.sample_channel !== want.sample_channel)
        report("sample_channel", 32'(got.sample_channel), 32'(want.sample_channel));
      if (got.sample_value !== want.sample_value)
        report("sample_value", 32'(got.sample_value), 32'(want.sample_value));
      if (got.gain_used !== want.gain_used)
        report("gain_used", 32'(got.gain_used), 32'(want.gain_used));
      if (got.gain_next !== want.gain_next)
        report("gain_next", 32'(got.gain_next), 32'(want.gain_next));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_req_t in_req = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_rsp_t out_rsp;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic cfg_ready;

  gain_scoreboard sb = new();
  int unsigned requests_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles = 0;
  bit no_gaps = 1'b0;

  adc_config_word_with_auto_gain #(
    .NUM_CHANNELS(CHANNELS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_req_t make_req(logic [1:0] op, logic [1:0] ch, int res,
                                       logic [2:0] gval);
    in_req_t req;
    req.operation = op;
    req.channel = ch;
    req.adc_result = 16'(res);
    req.gain_value = gval;
    return req;
  endfunction

  function automatic in_req_t random_request();
    in_req_t req;
    int unsigned pick;
    int mag;
    logic [15:0] lim;
    pick = $urandom_range(0, 99);
    if (pick < 45) req.operation = OP_SINGLE;
    else if (pick < 75) req.operation = OP_CONT;
    else if (pick < 90) req.operation = OP_SET_GAIN;
    else req.operation = OP_RESERVED;
    req.channel = 2'($urandom_range(0, 3));
    req.gain_value = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // magnitudes right around the active limits
      lim = $urandom_range(0, 1) ? sb.settings.high_limit : sb.settings.low_limit;
      mag = int'(lim) + int'($urandom_range(0, 2)) - 1;
      if (mag > 32768) mag = 32768;
      if (mag < 0) mag = 0;
      if ($urandom_range(0, 1) == 1 || mag == 32768) req.adc_result = 16'(-mag);
      else req.adc_result = 16'(mag);
    end else if (pick < 45) begin
      case ($urandom_range(0, 4))
        0: req.adc_result = 16'h7FFF;
        1: req.adc_result = 16'h8000;
        2: req.adc_result = 16'h0000;
        3: req.adc_result = 16'hFFFF;
        default: req.adc_result = 16'h0001;
      endcase
    end else begin
      req.adc_result = 16'($urandom);
    end
    return req;
  endfunction

  task automatic send_request(in_req_t req);
    int unsigned gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
    reg_writes++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(logic diff, logic [2:0] rate, logic [3:0] mask,
                               logic [15:0] hi, logic [15:0] lo);
    settle();
    write_reg(CFG_DIFF_MODE, {15'd0, diff});
    write_reg(CFG_DATA_RATE, {13'd0, rate});
    write_reg(CFG_AGC_MASK, {12'd0, mask});
    write_reg(CFG_HIGH_LIMIT, hi);
    write_reg(CFG_LOW_LIMIT, lo);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // result side stalls, with long stretches of steady ready
  initial begin : result_stalls
    int unsigned gap;
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_rsp);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results still pending",
               IDLE_LIMIT, sb.expected_rsps.size());
      $display("adc_config_word_with_auto_gain test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults, auto gain off
    send_request(make_req(OP_SINGLE, 2'd0, 0, 3'd0));
    send_request(make_req(OP_CONT, 2'd2, 32767, 3'd3));
    send_request(make_req(OP_RESERVED, 2'd3, -1, 3'd7));
    send_request(make_req(OP_SET_GAIN, 2'd1, 0, 3'd4));

    apply_setting(1'b1, 3'd7, 4'hF, HIGH_LIMIT_RST, LOW_LIMIT_RST);
    send_request(make_req(OP_SINGLE, 2'd0, 32767, 3'd0));
    send_request(make_req(OP_SINGLE, 2'd0, -32768, 3'd0));
    send_request(make_req(OP_CONT, 2'd1, -32768, 3'd0));
    send_request(make_req(OP_SINGLE, 2'd1, 0, 3'd0));
    send_request(make_req(OP_CONT, 2'd0, 0, 3'd0));
    // codes above the stepping range
    send_request(make_req(OP_SET_GAIN, 2'd2, 0, 3'd7));
    send_request(make_req(OP_SINGLE, 2'd2, 32767, 3'd0));
    send_request(make_req(OP_SINGLE, 2'd2, 0, 3'd0));
    send_request(make_req(OP_SET_GAIN, 2'd3, 0, 3'd6));
    send_request(make_req(OP_CONT, 2'd0, -1, 3'd0));
    // limits hit exactly and one past
    send_request(make_req(OP_SET_GAIN, 2'd3, 0, 3'd0));
    send_request(make_req(OP_SINGLE, 2'd3, -26214, 3'd0));
    send_request(make_req(OP_SINGLE, 2'd3, 6552, 3'd0));
    send_request(make_req(OP_SINGLE, 2'd3, 6553, 3'd0));
    send_request(make_req(OP_SINGLE, 2'd3, 26213, 3'd0));
    send_request(make_req(OP_SINGLE, 2'd3, 26214, 3'd0));
    send_request(make_req(OP_SINGLE, 2'd3, -6553, 3'd0));
    send_request(make_req(OP_RESERVED, 2'd1, 32767, 3'd5));
    send_request(make_req(OP_SET_GAIN, 2'd0, 0, 3'd5));
    send_request(make_req(OP_SINGLE, 2'd0, -1, 3'd0));

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_setting(1'b0, 3'd0, 4'b0101, 16'd0, 16'd0);
        1: apply_setting(1'b1, 3'd7, 4'b1010, 16'hFFFF, 16'hFFFF);
        2: apply_setting(1'b0, 3'd5, 4'hF, 16'd32768, 16'd0);
        3: apply_setting(1'b1, 3'd2, 4'hF, 16'd32767, 16'd32768);
        default: apply_setting(1'($urandom), 3'($urandom), 4'($urandom),
                               16'($urandom_range(16384, 32768)),
                               16'($urandom_range(0, 16383)));
      endcase
      no_gaps = (ph == 3 || ph == 6);
      repeat (PHASE_ITEMS) send_request(random_request());
    end

    settle();
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, sb.checked, sb.mismatches);
    $display("%0d register writes across %0d settings, limits and masks at both extremes",
             reg_writes, settings_used);
    if (sb.mismatches == 0) begin
      $display("adc_config_word_with_auto_gain test passed");
    end else begin
      $display("adc_config_word_with_auto_gain test failed");
    end
    $finish;
  end

endmodule

FILE: adc_config_word_with_auto_gain.f
src/adcagc_pkg.sv
src/adcagc_cfg_regs.sv
src/adcagc_item_eval.sv
src/adc_config_word_with_auto_gain.sv
src/adcagc_checker.sv
tb/sv/adc_config_word_with_auto_gain_test.sv
